FILE: hw/rtl/msrs_pkg.sv
// msrs_pkg: shared types and constants for the member set rank/select unit
// used by msrs_cell, member_set_rank_select_unit and msrs_checker; no dependencies
`default_nettype none

package msrs_pkg;

    // membership bits held by one cell of the chain
    localparam int CELL_W     = 8;
    localparam int CELL_IDX_W = 3;

    localparam int OP_W    = 2;
    localparam int ID_W    = 6;
    localparam int COUNT_W = 7;
    localparam int POP_W   = 4;

    localparam logic [OP_W-1:0] OP_QUERY = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
    localparam logic [OP_W-1:0] OP_DEL   = 2'd2;

    // scan token passed from cell to cell
    typedef struct packed {
        logic               valid;
        logic               member;
        logic               found;
        logic [COUNT_W-1:0] count;
        logic [COUNT_W-1:0] rank;
        logic [ID_W-1:0]    sel;
    } scan_tok_t;

endpackage

`default_nettype wire

FILE: hw/rtl/msrs_cell.sv
// msrs_cell: one slice of the membership bitmap plus its stage of the scan
// depends on msrs_pkg
`default_nettype none

module msrs_cell #(
    parameter int BASE      = 0,
    parameter int MAX_UNITS = 64
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          hold,
    input  wire                          wr_en,
    input  wire [msrs_pkg::OP_W-1:0]     wr_op,
    input  wire [msrs_pkg::ID_W-1:0]     wr_uid,
    input  wire [msrs_pkg::ID_W-1:0]     scan_uid,
    input  wire [msrs_pkg::ID_W-1:0]     scan_rq,
    input  msrs_pkg::scan_tok_t          tok_in,
    output msrs_pkg::scan_tok_t          tok_out
);
    import msrs_pkg::*;

    logic [CELL_W-1:0] chunk_reg;
    logic [CELL_W-1:0] chunk_next;
    scan_tok_t         tok_reg;
    scan_tok_t         tok_next;

    // update of the owned bits
    always_comb
    begin
        chunk_next = chunk_reg;
        if (wr_en)
        begin
            for (int j = 0; j < CELL_W; j++)
            begin
                if ((BASE + j == int'(wr_uid)) && (BASE + j < MAX_UNITS))
                begin
                    case (wr_op)
                        OP_ADD:  chunk_next[j] = 1'b1;
                        OP_DEL:  chunk_next[j] = 1'b0;
                        default: chunk_next[j] = chunk_reg[j];
                    endcase
                end
            end
        end
    end

    // scan step over the owned bits
    always_comb
    begin
        logic [POP_W-1:0]      pop;
        logic [POP_W-1:0]      below;
        logic [POP_W-1:0]      seen;
        logic [COUNT_W-1:0]    remaining;
        logic                  hit;
        logic                  mem;
        logic [CELL_IDX_W-1:0] pos;

        pop       = '0;
        below     = '0;
        seen      = '0;
        hit       = 1'b0;
        mem       = 1'b0;
        pos       = '0;
        remaining = {1'b0, scan_rq} - tok_in.count;
        for (int j = 0; j < CELL_W; j++)
        begin
            if (BASE + j == int'(scan_uid))
            begin
                mem = chunk_reg[j];
            end
            if (chunk_reg[j])
            begin
                pop = pop + POP_W'(1);
                if (BASE + j < int'(scan_uid))
                begin
                    below = below + POP_W'(1);
                end
                if (!hit && ({3'b000, seen} == remaining))
                begin
                    hit = 1'b1;
                    pos = CELL_IDX_W'(j);
                end
                seen = seen + POP_W'(1);
            end
        end

        tok_next       = tok_in;
        tok_next.count = tok_in.count + {3'b000, pop};
        tok_next.rank  = tok_in.rank + {3'b000, below};
        tok_next.member = tok_in.member | mem;
        // first cell that covers the asked index owns the select answer
        if (!tok_in.found && hit && ({1'b0, scan_rq} >= tok_in.count))
        begin
            tok_next.found = 1'b1;
            tok_next.sel   = ID_W'(BASE + int'(pos));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunk_reg <= '0;
            tok_reg   <= '0;
        end
        else
        begin
            chunk_reg <= chunk_next;
            if (!hold)
            begin
                tok_reg <= tok_next;
            end
        end
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/member_set_rank_select_unit.sv
// the input transaction updates the bitmap and registers the operands; a single
// scan token then walks the cell chain, one cell per cycle unless the full
// result register stalls it, and the next item waits until it leaves the chain
// reset: asynchronous active low, bitmap cleared (no members), no result held
`default_nettype none

module member_set_rank_select_unit #(
    parameter int MAX_UNITS = 64
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          in_valid,
    output logic                         in_ready,
    input  wire [msrs_pkg::OP_W-1:0]     op,
    input  wire [msrs_pkg::ID_W-1:0]     unit_id,
    input  wire [msrs_pkg::ID_W-1:0]     rank_query,
    output logic                         out_valid,
    input  wire                          out_ready,
    output logic                         is_member,
    output logic [msrs_pkg::ID_W-1:0]    local_rank,
    output logic [msrs_pkg::ID_W-1:0]    global_at_rank,
    output logic                         rank_valid,
    output logic [msrs_pkg::COUNT_W-1:0] member_count
);
    import msrs_pkg::*;

    // one cell per eight ids, last cell partly unused for odd sizes
    localparam int NUM_CELLS = (MAX_UNITS + CELL_W - 1) / CELL_W;

    logic in_fire;
    logic out_fire;
    logic tail_fire;
    logic tail_stall;

    // control
    logic busy_reg;
    logic busy_next;
    logic start_reg;
    logic out_valid_reg;
    logic out_valid_next;

    // operands held for the whole scan
    logic [ID_W-1:0] uid_reg;
    logic [ID_W-1:0] rq_reg;

    // result register
    logic               member_reg;
    logic [ID_W-1:0]    rank_reg;
    logic [ID_W-1:0]    sel_reg;
    logic               found_reg;
    logic [COUNT_W-1:0] count_reg;

    scan_tok_t tok [0:NUM_CELLS];

    assign in_ready  = !busy_reg;
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid_reg && out_ready;
    // token leaves the last cell once the result register is free
    assign tail_fire  = tok[NUM_CELLS].valid && (!out_valid_reg || out_ready);
    assign tail_stall = tok[NUM_CELLS].valid && !tail_fire;

    // fresh token enters the chain the cycle after the bitmap update
    always_comb
    begin
        tok[0]       = '0;
        tok[0].valid = start_reg;
    end

    for (genvar g = 0; g < NUM_CELLS; g++)
    begin : g_cell
        msrs_cell #(
            .BASE      (g * CELL_W),
            .MAX_UNITS (MAX_UNITS)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .hold     (tail_stall),
            .wr_en    (in_fire),
            .wr_op    (op),
            .wr_uid   (unit_id),
            .scan_uid (uid_reg),
            .scan_rq  (rq_reg),
            .tok_in   (tok[g]),
            .tok_out  (tok[g+1])
        );
    end

    always_comb
    begin
        busy_next = busy_reg;
        if (in_fire)
        begin
            busy_next = 1'b1;
        end
        else if (tail_fire)
        begin
            busy_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (tail_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_fire)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            start_reg     <= in_fire;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            uid_reg <= unit_id;
            rq_reg  <= rank_query;
        end
        if (tail_fire)
        begin
            member_reg <= tok[NUM_CELLS].member;
            rank_reg   <= tok[NUM_CELLS].rank[ID_W-1:0];
            sel_reg    <= tok[NUM_CELLS].found ? tok[NUM_CELLS].sel : '0;
            found_reg  <= tok[NUM_CELLS].found;
            count_reg  <= tok[NUM_CELLS].count;
        end
    end

    assign out_valid      = out_valid_reg;
    assign is_member      = member_reg;
    assign local_rank     = rank_reg;
    assign global_at_rank = sel_reg;
    assign rank_valid     = found_reg;
    assign member_count   = count_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/msrs_checker.sv
// msrs_checker: port-level assertions for member_set_rank_select_unit
// depends on msrs_pkg; bound to the top level at the end of this file
`default_nettype none

module msrs_checker (
    input wire                          clk,
    input wire                          rst_n,
    input wire                          in_valid,
    input wire                          in_ready,
    input wire                          out_valid,
    input wire                          out_ready,
    input wire                          is_member,
    input wire [msrs_pkg::ID_W-1:0]     local_rank,
    input wire [msrs_pkg::ID_W-1:0]     global_at_rank,
    input wire                          rank_valid,
    input wire [msrs_pkg::COUNT_W-1:0]  member_count
);
    import msrs_pkg::*;

    // unit takes one item at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted while scan in progress");

    // failed select reads as zero
    a_sel_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !rank_valid) |-> (global_at_rank == '0))
        else $error("global_at_rank nonzero without rank_valid");

    // a valid select needs at least one member
    a_sel_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (rank_valid || is_member)) |-> (member_count != '0))
        else $error("member reported with empty set");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped before transaction");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            ($stable(local_rank) && $stable(global_at_rank) && $stable(member_count)))
        else $error("result changed while stalled");

endmodule

bind member_set_rank_select_unit msrs_checker u_msrs_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .is_member      (is_member),
    .local_rank     (local_rank),
    .global_at_rank (global_at_rank),
    .rank_valid     (rank_valid),
    .member_count   (member_count)
);

`default_nettype wire
